>>> hw/rtl/crg_pkg.sv
// Shared constants and types for the camera ray generator.
`timescale 1ns / 1ps

package crg_pkg;

   localparam int COORD_W    = 12;
   localparam int JIT_W      = 16;
   localparam int DIR_W      = 16;
   localparam int SIZE_W     = 13;
   localparam int SCALE_W    = 16;
   localparam int COMP_W     = 16;
   localparam int BASIS_W    = 48;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 48;
   localparam int NORM_W     = 30;

   localparam logic [CSR_IDX_W-1:0] REG_WIDTH  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_HEIGHT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_HSCALE = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_VSCALE = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_RIGHT  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_UP     = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_BACK   = 3'd6;

   localparam logic [SIZE_W-1:0]  RST_WIDTH  = 13'd640;
   localparam logic [SIZE_W-1:0]  RST_HEIGHT = 13'd480;
   localparam logic [SCALE_W-1:0] RST_HSCALE = 16'd2261;
   localparam logic [SCALE_W-1:0] RST_VSCALE = 16'd1697;
   localparam logic [BASIS_W-1:0] RST_RIGHT  = 48'h0000_0000_4000;
   localparam logic [BASIS_W-1:0] RST_UP     = 48'h0000_4000_0000;
   localparam logic [BASIS_W-1:0] RST_BACK   = 48'h4000_0000_0000;

   typedef struct packed {
      logic [SIZE_W-1:0]  width;
      logic [SIZE_W-1:0]  height;
      logic [SCALE_W-1:0] hscale;
      logic [SCALE_W-1:0] vscale;
      logic [BASIS_W-1:0] right;
      logic [BASIS_W-1:0] up;
      logic [BASIS_W-1:0] back;
   } cfg_type;

endpackage

>>> hw/rtl/crg_div.sv
// Pipelined restoring divider, one quotient bit per stage.
`timescale 1ns / 1ps

module crg_div #(
   parameter int NB = 47,
   parameter int DB = 27,
   parameter int QB = 32,
   parameter int TW = 1
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   input  logic [NB-1:0] in_num,
   input  logic [DB-1:0] in_den,
   input  logic [TW-1:0] in_tag,
   output logic          out_valid,
   output logic [QB-1:0] out_quo,
   output logic [TW-1:0] out_tag
);

   logic [DB-1:0] rem_w [0:QB];
   logic [QB-1:0] quo_w [0:QB];
   logic [QB-1:0] num_w [0:QB];
   logic [DB-1:0] den_w [0:QB];
   logic [TW-1:0] tag_w [0:QB];
   logic          vld_w [0:QB];

   assign rem_w[0] = DB'(in_num[NB-1:QB]);
   assign quo_w[0] = '0;
   assign num_w[0] = in_num[QB-1:0];
   assign den_w[0] = in_den;
   assign tag_w[0] = in_tag;
   assign vld_w[0] = in_valid;

   for (genvar s = 0; s < QB; s++) begin : g_stage
      logic [DB:0]   trial;
      logic          fit;
      logic [DB-1:0] rem_in, rem_ff;
      logic [QB-1:0] quo_in, quo_ff;
      logic [QB-1:0] num_in, num_ff;
      logic [DB-1:0] den_ff;
      logic [TW-1:0] tag_ff;
      logic          vld_ff;

      always_comb begin
         trial  = {rem_w[s], num_w[s][QB-1]};
         fit    = (trial >= {1'b0, den_w[s]});
         rem_in = fit ? DB'(trial - {1'b0, den_w[s]}) : DB'(trial);
         quo_in = {quo_w[s][QB-2:0], fit};
         num_in = num_w[s] << 1;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff <= 1'b0;
         end else begin
            vld_ff <= vld_w[s];
         end
         rem_ff <= rem_in;
         quo_ff <= quo_in;
         num_ff <= num_in;
         den_ff <= den_w[s];
         tag_ff <= tag_w[s];
      end

      assign rem_w[s+1] = rem_ff;
      assign quo_w[s+1] = quo_ff;
      assign num_w[s+1] = num_ff;
      assign den_w[s+1] = den_ff;
      assign tag_w[s+1] = tag_ff;
      assign vld_w[s+1] = vld_ff;
   end

   assign out_valid = vld_w[QB];
   assign out_quo   = quo_w[QB];
   assign out_tag   = tag_w[QB];

endmodule

>>> hw/rtl/crg_norm.sv
// Pipelined block normalizer for three magnitudes sharing one shift.
`timescale 1ns / 1ps

module crg_norm #(
   parameter int MW = 50,
   parameter int TW = 1
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   input  logic [MW-1:0]             in_mag [3],
   input  logic [TW-1:0]             in_tag,
   output logic                      out_valid,
   output logic [crg_pkg::NORM_W-1:0] out_norm [3],
   output logic [TW-1:0]             out_tag
);

   localparam int SH = $clog2(MW);

   logic [MW-1:0] mag_w [0:SH][3];
   logic [TW-1:0] tag_w [0:SH];
   logic          vld_w [0:SH];

   assign mag_w[0] = in_mag;
   assign tag_w[0] = in_tag;
   assign vld_w[0] = in_valid;

   for (genvar s = 0; s < SH; s++) begin : g_stage
      localparam int STEP = 1 << (SH - 1 - s);
      logic [MW-1:0] any_w;
      logic [MW-1:0] mag_in [3];
      logic [MW-1:0] mag_ff [3];
      logic [TW-1:0] tag_ff;
      logic          vld_ff;

      // Shift left whenever the top STEP bits of all three are clear.
      always_comb begin
         any_w = mag_w[s][0] | mag_w[s][1] | mag_w[s][2];
         for (int k = 0; k < 3; k++) begin
            mag_in[k] = (any_w[MW-1 -: STEP] == '0) ? (mag_w[s][k] << STEP) : mag_w[s][k];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff <= 1'b0;
         end else begin
            vld_ff <= vld_w[s];
         end
         mag_ff <= mag_in;
         tag_ff <= tag_w[s];
      end

      assign mag_w[s+1] = mag_ff;
      assign tag_w[s+1] = tag_ff;
      assign vld_w[s+1] = vld_ff;
   end

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         out_norm[k] = mag_w[SH][k][MW-1 -: crg_pkg::NORM_W];
      end
   end

   assign out_valid = vld_w[SH];
   assign out_tag   = tag_w[SH];

endmodule

>>> hw/rtl/crg_sqrt.sv
// Pipelined integer square root, one root bit per stage.
`timescale 1ns / 1ps

module crg_sqrt #(
   parameter int XB = 62,
   parameter int TW = 1
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   input  logic [XB-1:0]           in_x,
   input  logic [TW-1:0]           in_tag,
   output logic                    out_valid,
   output logic [(XB+1)/2-1:0]     out_root,
   output logic [TW-1:0]           out_tag
);

   localparam int RB = (XB + 1) / 2;

   logic [XB-1:0] rem_w  [0:RB];
   logic [RB-1:0] root_w [0:RB];
   logic [TW-1:0] tag_w  [0:RB];
   logic          vld_w  [0:RB];

   assign rem_w[0]  = in_x;
   assign root_w[0] = '0;
   assign tag_w[0]  = in_tag;
   assign vld_w[0]  = in_valid;

   for (genvar s = 0; s < RB; s++) begin : g_stage
      localparam int B = RB - 1 - s;
      logic [XB:0]   inc;
      logic          fit;
      logic [XB-1:0] rem_in, rem_ff;
      logic [RB-1:0] root_in, root_ff;
      logic [TW-1:0] tag_ff;
      logic          vld_ff;

      // Growth of root squared when bit B is set: root*2^(B+1) + 4^B.
      always_comb begin
         inc     = ((XB+1)'(root_w[s]) << (B + 1)) | ((XB+1)'(1) << (2 * B));
         fit     = ({1'b0, rem_w[s]} >= inc);
         rem_in  = fit ? XB'({1'b0, rem_w[s]} - inc) : rem_w[s];
         root_in = fit ? (root_w[s] | (RB'(1) << B)) : root_w[s];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff <= 1'b0;
         end else begin
            vld_ff <= vld_w[s];
         end
         rem_ff  <= rem_in;
         root_ff <= root_in;
         tag_ff  <= tag_w[s];
      end

      assign rem_w[s+1]  = rem_ff;
      assign root_w[s+1] = root_ff;
      assign tag_w[s+1]  = tag_ff;
      assign vld_w[s+1]  = vld_ff;
   end

   assign out_valid = vld_w[RB];
   assign out_root  = root_w[RB];
   assign out_tag   = tag_w[RB];

endmodule

>>> hw/rtl/camera_ray_generation.sv
// Top level of the pinhole camera primary ray generator.
// Usage:
//   Request channel: drive req_pixel_col/row and req_jitter_col/row with start
//   high; the request is taken at a rising edge with start high and busy low.
//   busy stays low, so a new request may enter on every cycle.
//   Result channel: rsp_strobe is high for one cycle with the unit direction
//   (Q2.14 at the default FRAC_BITS) and the pixel coordinates. The receiver
//   cannot stall; it must take every result in the cycle it appears.
//   Throughput is one request per cycle. The pipeline holds the bit-per-stage
//   screen offset dividers (FRAC_BITS+18 stages), the square root (31 stages)
//   and the direction dividers (FRAC_BITS+2 stages).
//   Configuration: csr_wr_en with csr_index and csr_wdata writes one register
//   per cycle; write only while no request is in flight.
//   Reset (synchronous) restores the register defaults and drops every request
//   in flight; no result appears for requests taken before reset.
`timescale 1ns / 1ps

module camera_ray_generation #(
   parameter int COORD_BITS = 12,
   parameter int FRAC_BITS  = 14
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [crg_pkg::COORD_W-1:0]       req_pixel_col,
   input  logic [crg_pkg::COORD_W-1:0]       req_pixel_row,
   input  logic [crg_pkg::JIT_W-1:0]         req_jitter_col,
   input  logic [crg_pkg::JIT_W-1:0]         req_jitter_row,
   output logic                              rsp_strobe,
   output logic signed [crg_pkg::DIR_W-1:0]  rsp_dir_x,
   output logic signed [crg_pkg::DIR_W-1:0]  rsp_dir_y,
   output logic signed [crg_pkg::DIR_W-1:0]  rsp_dir_z,
   output logic [crg_pkg::COORD_W-1:0]       rsp_out_col,
   output logic [crg_pkg::COORD_W-1:0]       rsp_out_row,
   input  logic                              csr_wr_en,
   input  logic [crg_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [crg_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int CRD_W  = (COORD_BITS < crg_pkg::COORD_W) ? COORD_BITS : crg_pkg::COORD_W;
   localparam int CR_W   = 2 * CRD_W;
   localparam int F      = FRAC_BITS;
   localparam int NA_W   = 31;                 // signed screen numerator
   localparam int MAG_W  = 30;
   localparam int PA_W   = MAG_W + crg_pkg::SCALE_W;
   localparam int NB1    = PA_W + 1;
   localparam int DB1    = crg_pkg::SIZE_W + 28 - F;
   localparam int QB1    = F + 18;
   localparam int AQ_W   = F + 19;
   localparam int PR_W   = AQ_W + crg_pkg::COMP_W;
   localparam int CW     = F + 36;
   localparam int SQ_W   = 2 * crg_pkg::NORM_W;
   localparam int SUM_W  = SQ_W + 2;
   localparam int LEN_W  = (SUM_W + 1) / 2;
   localparam int NB2    = crg_pkg::NORM_W + F + 1;
   localparam int QB2    = F + 2;
   localparam int NT_W   = 4 + CR_W;           // signs, zero flag, coordinates
   localparam int ST_W   = 3 * crg_pkg::NORM_W + NT_W;

   // ---------------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------------
   crg_pkg::cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.width  <= crg_pkg::RST_WIDTH;
         cfg_ff.height <= crg_pkg::RST_HEIGHT;
         cfg_ff.hscale <= crg_pkg::RST_HSCALE;
         cfg_ff.vscale <= crg_pkg::RST_VSCALE;
         cfg_ff.right  <= crg_pkg::RST_RIGHT;
         cfg_ff.up     <= crg_pkg::RST_UP;
         cfg_ff.back   <= crg_pkg::RST_BACK;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            crg_pkg::REG_WIDTH:  cfg_ff.width  <= csr_wdata[crg_pkg::SIZE_W-1:0];
            crg_pkg::REG_HEIGHT: cfg_ff.height <= csr_wdata[crg_pkg::SIZE_W-1:0];
            crg_pkg::REG_HSCALE: cfg_ff.hscale <= csr_wdata[crg_pkg::SCALE_W-1:0];
            crg_pkg::REG_VSCALE: cfg_ff.vscale <= csr_wdata[crg_pkg::SCALE_W-1:0];
            crg_pkg::REG_RIGHT:  cfg_ff.right  <= csr_wdata[crg_pkg::BASIS_W-1:0];
            crg_pkg::REG_UP:     cfg_ff.up     <= csr_wdata[crg_pkg::BASIS_W-1:0];
            crg_pkg::REG_BACK:   cfg_ff.back   <= csr_wdata[crg_pkg::BASIS_W-1:0];
            default: ;  // index past the register list: drop the write
         endcase
      end
   end

   // Treat a zero image size as one pixel.
   logic [crg_pkg::SIZE_W-1:0] wd_w, ht_w;
   logic [DB1-1:0]             den_a_w, den_b_w;

   assign wd_w    = (cfg_ff.width  == '0) ? crg_pkg::SIZE_W'(1) : cfg_ff.width;
   assign ht_w    = (cfg_ff.height == '0) ? crg_pkg::SIZE_W'(1) : cfg_ff.height;
   assign den_a_w = DB1'(wd_w) << (28 - F);
   assign den_b_w = DB1'(ht_w) << (28 - F);

   // The pipeline never holds off a request.
   assign busy = 1'b0;

   // ---------------------------------------------------------------------
   // Stage 1: signed screen numerators na = 2(i+jx) - W, nb = H - 2(j+jy)
   // ---------------------------------------------------------------------
   logic                   s1_vld_in, s1_vld_ff;
   logic [NA_W-1:0]        s1_na_in, s1_na_ff, s1_nb_in, s1_nb_ff;
   logic [CR_W-1:0]        s1_cr_in, s1_cr_ff;
   logic [CRD_W-1:0]       col_w, row_w;

   always_comb begin
      col_w     = CRD_W'(req_pixel_col);
      row_w     = CRD_W'(req_pixel_row);
      s1_vld_in = start & ~busy;
      s1_na_in  = NA_W'({col_w, req_jitter_col, 1'b0}) - NA_W'({wd_w, 16'd0});
      s1_nb_in  = NA_W'({ht_w, 16'd0}) - NA_W'({row_w, req_jitter_row, 1'b0});
      s1_cr_in  = {col_w, row_w};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= s1_vld_in;
      end
      s1_na_ff <= s1_na_in;
      s1_nb_ff <= s1_nb_in;
      s1_cr_ff <= s1_cr_in;
   end

   // ---------------------------------------------------------------------
   // Stage 2: split into sign and magnitude
   // ---------------------------------------------------------------------
   logic             s2_vld_ff, s2_sa_ff, s2_sb_ff;
   logic [MAG_W-1:0] s2_ma_in, s2_ma_ff, s2_mb_in, s2_mb_ff;
   logic [CR_W-1:0]  s2_cr_ff;

   always_comb begin
      s2_ma_in = s1_na_ff[NA_W-1] ? MAG_W'(-s1_na_ff) : MAG_W'(s1_na_ff);
      s2_mb_in = s1_nb_ff[NA_W-1] ? MAG_W'(-s1_nb_ff) : MAG_W'(s1_nb_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_vld_ff <= 1'b0;
      end else begin
         s2_vld_ff <= s1_vld_ff;
      end
      s2_sa_ff <= s1_na_ff[NA_W-1];
      s2_sb_ff <= s1_nb_ff[NA_W-1];
      s2_ma_ff <= s2_ma_in;
      s2_mb_ff <= s2_mb_in;
      s2_cr_ff <= s1_cr_ff;
   end

   // ---------------------------------------------------------------------
   // Stage 3: scale the magnitudes
   // ---------------------------------------------------------------------
   logic            s3_vld_ff, s3_sa_ff, s3_sb_ff;
   logic [PA_W-1:0] s3_pa_in, s3_pa_ff, s3_pb_in, s3_pb_ff;
   logic [CR_W-1:0] s3_cr_ff;

   always_comb begin
      s3_pa_in = PA_W'(s2_ma_ff) * PA_W'(cfg_ff.hscale);
      s3_pb_in = PA_W'(s2_mb_ff) * PA_W'(cfg_ff.vscale);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_vld_ff <= 1'b0;
      end else begin
         s3_vld_ff <= s2_vld_ff;
      end
      s3_sa_ff <= s2_sa_ff;
      s3_sb_ff <= s2_sb_ff;
      s3_pa_ff <= s3_pa_in;
      s3_pb_ff <= s3_pb_in;
      s3_cr_ff <= s2_cr_ff;
   end

   // ---------------------------------------------------------------------
   // Stage 4: add half the divisor for round to nearest
   // ---------------------------------------------------------------------
   logic            s4_vld_ff, s4_sa_ff, s4_sb_ff;
   logic [NB1-1:0]  s4_na_in, s4_na_ff, s4_nb_in, s4_nb_ff;
   logic [CR_W-1:0] s4_cr_ff;

   always_comb begin
      s4_na_in = NB1'(s3_pa_ff) + NB1'(den_a_w >> 1);
      s4_nb_in = NB1'(s3_pb_ff) + NB1'(den_b_w >> 1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_vld_ff <= 1'b0;
      end else begin
         s4_vld_ff <= s3_vld_ff;
      end
      s4_sa_ff <= s3_sa_ff;
      s4_sb_ff <= s3_sb_ff;
      s4_na_ff <= s4_na_in;
      s4_nb_ff <= s4_nb_in;
      s4_cr_ff <= s3_cr_ff;
   end

   // ---------------------------------------------------------------------
   // Screen offset dividers: alpha and beta magnitudes
   // ---------------------------------------------------------------------
   logic            da_vld_w, db_vld_w;
   logic [QB1-1:0]  da_q_w, db_q_w;
   logic [CR_W:0]   da_tag_w;
   logic            db_tag_w;

   crg_div #(.NB(NB1), .DB(DB1), .QB(QB1), .TW(CR_W + 1)) u_div_alpha (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s4_vld_ff),
      .in_num    (s4_na_ff),
      .in_den    (den_a_w),
      .in_tag    ({s4_sa_ff, s4_cr_ff}),
      .out_valid (da_vld_w),
      .out_quo   (da_q_w),
      .out_tag   (da_tag_w)
   );

   crg_div #(.NB(NB1), .DB(DB1), .QB(QB1), .TW(1)) u_div_beta (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s4_vld_ff),
      .in_num    (s4_nb_ff),
      .in_den    (den_b_w),
      .in_tag    (s4_sb_ff),
      .out_valid (db_vld_w),
      .out_quo   (db_q_w),
      .out_tag   (db_tag_w)
   );

   // ---------------------------------------------------------------------
   // Stage 5: reapply signs to alpha and beta
   // ---------------------------------------------------------------------
   logic                   s5_vld_ff;
   logic signed [AQ_W-1:0] s5_aq_in, s5_aq_ff, s5_bq_in, s5_bq_ff;
   logic [CR_W-1:0]        s5_cr_ff;

   always_comb begin
      s5_aq_in = da_tag_w[CR_W] ? -AQ_W'(da_q_w) : AQ_W'(da_q_w);
      s5_bq_in = db_tag_w       ? -AQ_W'(db_q_w) : AQ_W'(db_q_w);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_vld_ff <= 1'b0;
      end else begin
         s5_vld_ff <= da_vld_w & db_vld_w;
      end
      s5_aq_ff <= s5_aq_in;
      s5_bq_ff <= s5_bq_in;
      s5_cr_ff <= da_tag_w[CR_W-1:0];
   end

   // ---------------------------------------------------------------------
   // Stage 6: alpha*u and beta*v per component
   // ---------------------------------------------------------------------
   logic signed [crg_pkg::COMP_W-1:0] u_w [3];
   logic signed [crg_pkg::COMP_W-1:0] v_w [3];
   logic signed [crg_pkg::COMP_W-1:0] w_w [3];

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         u_w[k] = cfg_ff.right[crg_pkg::COMP_W*k +: crg_pkg::COMP_W];
         v_w[k] = cfg_ff.up[crg_pkg::COMP_W*k +: crg_pkg::COMP_W];
         w_w[k] = cfg_ff.back[crg_pkg::COMP_W*k +: crg_pkg::COMP_W];
      end
   end

   logic                   s6_vld_ff;
   logic signed [PR_W-1:0] s6_pu_in [3];
   logic signed [PR_W-1:0] s6_pu_ff [3];
   logic signed [PR_W-1:0] s6_pv_in [3];
   logic signed [PR_W-1:0] s6_pv_ff [3];
   logic [CR_W-1:0]        s6_cr_ff;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         s6_pu_in[k] = PR_W'(s5_aq_ff) * PR_W'(u_w[k]);
         s6_pv_in[k] = PR_W'(s5_bq_ff) * PR_W'(v_w[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s6_vld_ff <= 1'b0;
      end else begin
         s6_vld_ff <= s5_vld_ff;
      end
      s6_pu_ff <= s6_pu_in;
      s6_pv_ff <= s6_pv_in;
      s6_cr_ff <= s5_cr_ff;
   end

   // ---------------------------------------------------------------------
   // Stage 7: d = alpha*u + beta*v - w
   // ---------------------------------------------------------------------
   logic                 s7_vld_ff;
   logic signed [CW-1:0] s7_c_in [3];
   logic signed [CW-1:0] s7_c_ff [3];
   logic [CR_W-1:0]      s7_cr_ff;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         s7_c_in[k] = CW'(s6_pu_ff[k]) + CW'(s6_pv_ff[k]) - (CW'(w_w[k]) <<< F);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s7_vld_ff <= 1'b0;
      end else begin
         s7_vld_ff <= s6_vld_ff;
      end
      s7_c_ff  <= s7_c_in;
      s7_cr_ff <= s6_cr_ff;
   end

   // ---------------------------------------------------------------------
   // Stage 8: component magnitudes, signs and the zero vector flag
   // ---------------------------------------------------------------------
   logic            s8_vld_ff, s8_zero_in, s8_zero_ff;
   logic [2:0]      s8_sgn_in, s8_sgn_ff;
   logic [CW-1:0]   s8_m_in [3];
   logic [CW-1:0]   s8_m_ff [3];
   logic [CR_W-1:0] s8_cr_ff;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         s8_sgn_in[k] = s7_c_ff[k][CW-1];
         s8_m_in[k]   = s8_sgn_in[k] ? CW'(-s7_c_ff[k]) : CW'(s7_c_ff[k]);
      end
      s8_zero_in = (s7_c_ff[0] == '0) && (s7_c_ff[1] == '0) && (s7_c_ff[2] == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s8_vld_ff <= 1'b0;
      end else begin
         s8_vld_ff <= s7_vld_ff;
      end
      s8_sgn_ff  <= s8_sgn_in;
      s8_zero_ff <= s8_zero_in;
      s8_m_ff    <= s8_m_in;
      s8_cr_ff   <= s7_cr_ff;
   end

   // ---------------------------------------------------------------------
   // Block normalization: largest magnitude lands in [2^29, 2^30)
   // ---------------------------------------------------------------------
   logic                       nm_vld_w;
   logic [crg_pkg::NORM_W-1:0] nm_n_w [3];
   logic [NT_W-1:0]            nm_tag_w;

   crg_norm #(.MW(CW), .TW(NT_W)) u_norm (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s8_vld_ff),
      .in_mag    (s8_m_ff),
      .in_tag    ({s8_sgn_ff, s8_zero_ff, s8_cr_ff}),
      .out_valid (nm_vld_w),
      .out_norm  (nm_n_w),
      .out_tag   (nm_tag_w)
   );

   // ---------------------------------------------------------------------
   // Stages 9 and 10: squares, then their sum
   // ---------------------------------------------------------------------
   logic                       s9_vld_ff;
   logic [SQ_W-1:0]            s9_sq_in [3];
   logic [SQ_W-1:0]            s9_sq_ff [3];
   logic [crg_pkg::NORM_W-1:0] s9_n_ff [3];
   logic [NT_W-1:0]            s9_tag_ff;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         s9_sq_in[k] = SQ_W'(nm_n_w[k]) * SQ_W'(nm_n_w[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s9_vld_ff <= 1'b0;
      end else begin
         s9_vld_ff <= nm_vld_w;
      end
      s9_sq_ff  <= s9_sq_in;
      s9_n_ff   <= nm_n_w;
      s9_tag_ff <= nm_tag_w;
   end

   logic                       s10_vld_ff;
   logic [SUM_W-1:0]           s10_sum_in, s10_sum_ff;
   logic [crg_pkg::NORM_W-1:0] s10_n_ff [3];
   logic [NT_W-1:0]            s10_tag_ff;

   assign s10_sum_in = SUM_W'(s9_sq_ff[0]) + SUM_W'(s9_sq_ff[1]) + SUM_W'(s9_sq_ff[2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         s10_vld_ff <= 1'b0;
      end else begin
         s10_vld_ff <= s9_vld_ff;
      end
      s10_sum_ff <= s10_sum_in;
      s10_n_ff   <= s9_n_ff;
      s10_tag_ff <= s9_tag_ff;
   end

   // ---------------------------------------------------------------------
   // Vector length
   // ---------------------------------------------------------------------
   logic             sq_vld_w;
   logic [LEN_W-1:0] sq_len_w;
   logic [ST_W-1:0]  sq_tag_w;

   crg_sqrt #(.XB(SUM_W), .TW(ST_W)) u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s10_vld_ff),
      .in_x      (s10_sum_ff),
      .in_tag    ({s10_n_ff[0], s10_n_ff[1], s10_n_ff[2], s10_tag_ff}),
      .out_valid (sq_vld_w),
      .out_root  (sq_len_w),
      .out_tag   (sq_tag_w)
   );

   // ---------------------------------------------------------------------
   // Stage 11: direction numerators n*2^F + len/2
   // ---------------------------------------------------------------------
   logic                       s11_vld_ff;
   logic [crg_pkg::NORM_W-1:0] sq_n_w [3];
   logic [NT_W-1:0]            sq_nt_w;
   logic [NB2-1:0]             s11_num_in [3];
   logic [NB2-1:0]             s11_num_ff [3];
   logic [LEN_W-1:0]           s11_len_ff;
   logic [NT_W-1:0]            s11_tag_ff;

   always_comb begin
      {sq_n_w[0], sq_n_w[1], sq_n_w[2], sq_nt_w} = sq_tag_w;
      for (int k = 0; k < 3; k++) begin
         s11_num_in[k] = (NB2'(sq_n_w[k]) << F) + NB2'(sq_len_w >> 1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s11_vld_ff <= 1'b0;
      end else begin
         s11_vld_ff <= sq_vld_w;
      end
      s11_num_ff <= s11_num_in;
      s11_len_ff <= sq_len_w;
      s11_tag_ff <= sq_nt_w;
   end

   // ---------------------------------------------------------------------
   // Direction dividers, one per component
   // ---------------------------------------------------------------------
   logic                 dx_vld_w, dy_vld_w, dz_vld_w;
   logic [QB2-1:0]       dx_q_w, dy_q_w, dz_q_w;
   logic [CR_W+1:0]      dx_tag_w;
   logic                 dy_tag_w, dz_tag_w;
   logic [2:0]           s11_sgn_w;
   logic                 s11_zero_w;
   logic [CR_W-1:0]      s11_cr_w;

   assign {s11_sgn_w, s11_zero_w, s11_cr_w} = s11_tag_ff;

   crg_div #(.NB(NB2), .DB(LEN_W), .QB(QB2), .TW(CR_W + 2)) u_div_x (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s11_vld_ff),
      .in_num    (s11_num_ff[0]),
      .in_den    (s11_len_ff),
      .in_tag    ({s11_sgn_w[0], s11_zero_w, s11_cr_w}),
      .out_valid (dx_vld_w),
      .out_quo   (dx_q_w),
      .out_tag   (dx_tag_w)
   );

   crg_div #(.NB(NB2), .DB(LEN_W), .QB(QB2), .TW(1)) u_div_y (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s11_vld_ff),
      .in_num    (s11_num_ff[1]),
      .in_den    (s11_len_ff),
      .in_tag    (s11_sgn_w[1]),
      .out_valid (dy_vld_w),
      .out_quo   (dy_q_w),
      .out_tag   (dy_tag_w)
   );

   crg_div #(.NB(NB2), .DB(LEN_W), .QB(QB2), .TW(1)) u_div_z (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s11_vld_ff),
      .in_num    (s11_num_ff[2]),
      .in_den    (s11_len_ff),
      .in_tag    (s11_sgn_w[2]),
      .out_valid (dz_vld_w),
      .out_quo   (dz_q_w),
      .out_tag   (dz_tag_w)
   );

   // ---------------------------------------------------------------------
   // Stage 12: clamp to one, clamp to the signed range, zero the zero vector, reapply sign
   // ---------------------------------------------------------------------
   function automatic logic [crg_pkg::DIR_W-1:0] to_dir(input logic [QB2-1:0] q,
                                                         input logic neg, input logic zero);
      logic [31:0]                qx;
      logic [crg_pkg::DIR_W-1:0] d;
      qx = 32'(q);
      if (qx > (32'd1 << F)) qx = 32'd1 << F;
      if (qx > 32'd32767)    qx = 32'd32767;
      d = crg_pkg::DIR_W'(qx);
      if (zero) d = '0;
      return neg ? -d : d;
   endfunction

   logic                      out_vld_ff;
   logic [crg_pkg::DIR_W-1:0] dir_x_in, dir_x_ff, dir_y_in, dir_y_ff, dir_z_in, dir_z_ff;
   logic [CRD_W-1:0]          col_ff, row_ff;
   logic                      dx_zero_w;

   always_comb begin
      dx_zero_w = dx_tag_w[CR_W];
      dir_x_in  = to_dir(dx_q_w, dx_tag_w[CR_W+1], dx_zero_w);
      dir_y_in  = to_dir(dy_q_w, dy_tag_w, dx_zero_w);
      dir_z_in  = to_dir(dz_q_w, dz_tag_w, dx_zero_w);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else begin
         out_vld_ff <= dx_vld_w & dy_vld_w & dz_vld_w;
      end
      dir_x_ff <= dir_x_in;
      dir_y_ff <= dir_y_in;
      dir_z_ff <= dir_z_in;
      {col_ff, row_ff} <= dx_tag_w[CR_W-1:0];
   end

   assign rsp_strobe  = out_vld_ff;
   assign rsp_dir_x   = dir_x_ff;
   assign rsp_dir_y   = dir_y_ff;
   assign rsp_dir_z   = dir_z_ff;
   assign rsp_out_col = crg_pkg::COORD_W'(col_ff);
   assign rsp_out_row = crg_pkg::COORD_W'(row_ff);

endmodule

>>> hw/rtl/crg_checker.sv
// Port-level checks for the camera ray generator, bound to the top level.
`timescale 1ns / 1ps

module crg_checker #(
   parameter int COORD_BITS = 12,
   parameter int FRAC_BITS  = 14
) (
   input logic                             clock,
   input logic                             reset,
   input logic                             start,
   input logic                             busy,
   input logic [crg_pkg::COORD_W-1:0]      req_pixel_col,
   input logic                             rsp_strobe,
   input logic signed [crg_pkg::DIR_W-1:0] rsp_dir_x,
   input logic [crg_pkg::COORD_W-1:0]      rsp_out_col
);

   localparam int CRD_W = (COORD_BITS < crg_pkg::COORD_W) ? COORD_BITS : crg_pkg::COORD_W;
   localparam int LAT   = 2 * FRAC_BITS + 63 + $clog2(FRAC_BITS + 36);
   localparam int LIM   = (FRAC_BITS >= 15) ? 32767 : (1 << FRAC_BITS);

   a_req_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LAT rsp_strobe)
      else $error("request produced no result at the fixed latency");

   a_rsp_has_req: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, LAT))
      else $error("result without a matching request");

   a_col_passes: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_out_col == crg_pkg::COORD_W'(CRD_W'($past(req_pixel_col, LAT)))))
      else $error("pixel column not carried with its result");

   a_dir_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (($signed(rsp_dir_x) <= LIM) && ($signed(rsp_dir_x) >= -LIM)))
      else $error("direction component beyond unit length");

endmodule

bind camera_ray_generation crg_checker #(
   .COORD_BITS (COORD_BITS),
   .FRAC_BITS  (FRAC_BITS)
) u_crg_checker (
   .clock         (clock),
   .reset         (reset),
   .start         (start),
   .busy          (busy),
   .req_pixel_col (req_pixel_col),
   .rsp_strobe    (rsp_strobe),
   .rsp_dir_x     (rsp_dir_x),
   .rsp_out_col   (rsp_out_col)
);

>>> tb/testbench.sv
// Self-checking testbench for the camera ray generator: random and directed requests.
`timescale 1ns / 1ps

module testbench;

   localparam int FRAC = 14;
   localparam int DRAIN_CYCLES = 120;          // more than the pipeline latency
   localparam int CYCLE_LIMIT = 400000;
   localparam logic [crg_pkg::CSR_IDX_W-1:0] REG_UNUSED = 3'd7;   // past the register list

   typedef struct packed {
      logic signed [crg_pkg::DIR_W-1:0] dir_x;
      logic signed [crg_pkg::DIR_W-1:0] dir_y;
      logic signed [crg_pkg::DIR_W-1:0] dir_z;
      logic [crg_pkg::COORD_W-1:0]      col;
      logic [crg_pkg::COORD_W-1:0]      row;
   } ray_type;

   // Hold the rays still to come, in request order; count mismatches.
   class ray_scoreboard_type;
      ray_type pending_rays[$];
      int      errors = 0;

      task report(string msg);
         $display("MISMATCH @%0t: %s", $realtime, msg);
         errors++;
      endtask

      function void note_request(ray_type exp_ray);
         pending_rays.push_back(exp_ray);
      endfunction

      task check_result(ray_type got);
         ray_type e;
         if (pending_rays.size() == 0) begin
            report("ray with no request outstanding");
            return;
         end
         e = pending_rays.pop_front();
         if (got.dir_x !== e.dir_x)
            report($sformatf("dir_x %0d, want %0d", got.dir_x, e.dir_x));
         if (got.dir_y !== e.dir_y)
            report($sformatf("dir_y %0d, want %0d", got.dir_y, e.dir_y));
         if (got.dir_z !== e.dir_z)
            report($sformatf("dir_z %0d, want %0d", got.dir_z, e.dir_z));
         if (got.col !== e.col)
            report($sformatf("col %0d, want %0d", got.col, e.col));
         if (got.row !== e.row)
            report($sformatf("row %0d, want %0d", got.row, e.row));
      endtask
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [crg_pkg::COORD_W-1:0] req_pixel_col = '0;
   logic [crg_pkg::COORD_W-1:0] req_pixel_row = '0;
   logic [crg_pkg::JIT_W-1:0]   req_jitter_col = '0;
   logic [crg_pkg::JIT_W-1:0]   req_jitter_row = '0;
   logic rsp_strobe;
   logic signed [crg_pkg::DIR_W-1:0] rsp_dir_x, rsp_dir_y, rsp_dir_z;
   logic [crg_pkg::COORD_W-1:0] rsp_out_col, rsp_out_row;
   logic csr_wr_en = 1'b0;
   logic [crg_pkg::CSR_IDX_W-1:0]  csr_index = '0;
   logic [crg_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   crg_pkg::cfg_type   cam_cfg;
   ray_scoreboard_type ray_sb = new();
   int                 cycle_count = 0;
   int                 burst_left = 0;

   camera_ray_generation dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_pixel_col(req_pixel_col), .req_pixel_row(req_pixel_row),
      .req_jitter_col(req_jitter_col), .req_jitter_row(req_jitter_row),
      .rsp_strobe(rsp_strobe), .rsp_dir_x(rsp_dir_x), .rsp_dir_y(rsp_dir_y),
      .rsp_dir_z(rsp_dir_z), .rsp_out_col(rsp_out_col), .rsp_out_row(rsp_out_row),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #10 clock = ~clock;

   // Round to nearest, ties away from zero; divisor is positive.
   function automatic longint div_nearest(longint n, longint d);
      longint mag;
      longint q;
      mag = (n < 0) ? -n : n;
      q = (mag + d / 2) / d;
      return (n < 0) ? -q : q;
   endfunction

   function automatic longint basis_comp(logic [crg_pkg::BASIS_W-1:0] b, int k);
      return longint'($signed(b[16*k +: 16]));
   endfunction

   function automatic longint int_sqrt(longint x);
      longint r;
      longint bitv;
      r = 0;
      bitv = longint'(1) <<< 62;
      while (bitv > x) bitv = bitv >>> 2;
      while (bitv != 0) begin
         if (x >= r + bitv) begin
            x = x - (r + bitv);
            r = (r >>> 1) + bitv;
         end else begin
            r = r >>> 1;
         end
         bitv = bitv >>> 2;
      end
      return r;
   endfunction

   // Compute the unit ray direction for one pixel sample under the given setup.
   function automatic ray_type trace_pixel(crg_pkg::cfg_type c,
                                           logic [crg_pkg::COORD_W-1:0] col,
                                           logic [crg_pkg::COORD_W-1:0] row,
                                           logic [crg_pkg::JIT_W-1:0] jx,
                                           logic [crg_pkg::JIT_W-1:0] jy);
      ray_type r;
      longint  wd, ht, na, nb, aq, bq, mx, sum, len, q;
      longint  cv[3];
      longint  mg[3];
      wd = (c.width == 0) ? 1 : longint'(c.width);
      ht = (c.height == 0) ? 1 : longint'(c.height);
      na = 2 * ((longint'(col) <<< 16) + longint'(jx)) - (wd <<< 16);
      nb = (ht <<< 16) - 2 * ((longint'(row) <<< 16) + longint'(jy));
      aq = div_nearest(na * longint'(c.hscale), wd <<< (28 - FRAC));
      bq = div_nearest(nb * longint'(c.vscale), ht <<< (28 - FRAC));
      mx = 0;
      for (int k = 0; k < 3; k++) begin
         cv[k] = aq * basis_comp(c.right, k) + bq * basis_comp(c.up, k)
               - basis_comp(c.back, k) * (longint'(1) <<< FRAC);
         mg[k] = (cv[k] < 0) ? -cv[k] : cv[k];
         if (mg[k] > mx) mx = mg[k];
      end
      r.col = col;
      r.row = row;
      if (mx == 0) begin
         r.dir_x = '0;
         r.dir_y = '0;
         r.dir_z = '0;
         return r;
      end
      while (mx >= (longint'(1) <<< 30)) begin
         mx = mx >>> 1;
         for (int k = 0; k < 3; k++) mg[k] = mg[k] >>> 1;
      end
      while (mx < (longint'(1) <<< 29)) begin
         mx = mx <<< 1;
         for (int k = 0; k < 3; k++) mg[k] = mg[k] <<< 1;
      end
      sum = 0;
      for (int k = 0; k < 3; k++) sum += mg[k] * mg[k];
      len = int_sqrt(sum);
      for (int k = 0; k < 3; k++) begin
         q = ((mg[k] <<< FRAC) + len / 2) / len;
         if (q > (longint'(1) <<< FRAC)) q = longint'(1) <<< FRAC;
         if (q > 32767) q = 32767;
         mg[k] = (cv[k] < 0) ? -q : q;
      end
      r.dir_x = mg[0][15:0];
      r.dir_y = mg[1][15:0];
      r.dir_z = mg[2][15:0];
      return r;
   endfunction

   // Monitor: sample everything at the edge, before any new drive takes effect.
   // Predict with the setup in force at acceptance, then apply a register write.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (reset) begin
         cam_cfg <= '{crg_pkg::RST_WIDTH, crg_pkg::RST_HEIGHT, crg_pkg::RST_HSCALE,
                      crg_pkg::RST_VSCALE, crg_pkg::RST_RIGHT, crg_pkg::RST_UP,
                      crg_pkg::RST_BACK};
      end else begin
         if (start && !busy)
            ray_sb.note_request(trace_pixel(cam_cfg, req_pixel_col, req_pixel_row,
                                            req_jitter_col, req_jitter_row));
         if (rsp_strobe)
            ray_sb.check_result('{rsp_dir_x, rsp_dir_y, rsp_dir_z,
                                  rsp_out_col, rsp_out_row});
         if (csr_wr_en) begin
            case (csr_index)
               crg_pkg::REG_WIDTH:  cam_cfg.width  <= csr_wdata[crg_pkg::SIZE_W-1:0];
               crg_pkg::REG_HEIGHT: cam_cfg.height <= csr_wdata[crg_pkg::SIZE_W-1:0];
               crg_pkg::REG_HSCALE: cam_cfg.hscale <= csr_wdata[crg_pkg::SCALE_W-1:0];
               crg_pkg::REG_VSCALE: cam_cfg.vscale <= csr_wdata[crg_pkg::SCALE_W-1:0];
               crg_pkg::REG_RIGHT:  cam_cfg.right  <= csr_wdata[crg_pkg::BASIS_W-1:0];
               crg_pkg::REG_UP:     cam_cfg.up     <= csr_wdata[crg_pkg::BASIS_W-1:0];
               crg_pkg::REG_BACK:   cam_cfg.back   <= csr_wdata[crg_pkg::BASIS_W-1:0];
               default: ;
            endcase
         end
      end
   end

   // Watchdog: give up if the run hangs.
   always @(posedge clock) begin
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[camera_ray_generation] ERROR");
         $finish;
      end
   end

   // Write one register; call only while the pipeline is empty. The write
   // enable stays high on return so writes can follow back to back; drop it
   // once the last write of a group has gone in.
   task automatic write_reg(logic [crg_pkg::CSR_IDX_W-1:0] idx,
                            logic [crg_pkg::CSR_DATA_W-1:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   task automatic write_setup(logic [crg_pkg::SIZE_W-1:0] w, logic [crg_pkg::SIZE_W-1:0] h,
                              logic [crg_pkg::SCALE_W-1:0] hs,
                              logic [crg_pkg::SCALE_W-1:0] vs,
                              logic [crg_pkg::BASIS_W-1:0] u, logic [crg_pkg::BASIS_W-1:0] v,
                              logic [crg_pkg::BASIS_W-1:0] b);
      write_reg(crg_pkg::REG_WIDTH, crg_pkg::CSR_DATA_W'(w));
      write_reg(crg_pkg::REG_HEIGHT, crg_pkg::CSR_DATA_W'(h));
      write_reg(crg_pkg::REG_HSCALE, crg_pkg::CSR_DATA_W'(hs));
      write_reg(crg_pkg::REG_VSCALE, crg_pkg::CSR_DATA_W'(vs));
      write_reg(crg_pkg::REG_RIGHT, u);
      write_reg(crg_pkg::REG_UP, v);
      write_reg(crg_pkg::REG_BACK, b);
   endtask

   // Offer one request and hold it until taken. Start stays high on return so
   // the next request can follow back to back; a burst end drops it for a gap.
   task automatic send_pixel(logic [crg_pkg::COORD_W-1:0] col,
                             logic [crg_pkg::COORD_W-1:0] row,
                             logic [crg_pkg::JIT_W-1:0] jx, logic [crg_pkg::JIT_W-1:0] jy);
      if (burst_left == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? 60 : $urandom_range(1, 12);
      end
      req_pixel_col  <= col;
      req_pixel_row  <= row;
      req_jitter_col <= jx;
      req_jitter_row <= jy;
      start <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      burst_left--;
   endtask

   // Drop start, then wait out every outstanding ray plus the pipeline depth.
   task automatic drain;
      start <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (ray_sb.pending_rays.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic logic [crg_pkg::COMP_W-1:0] pick_comp();
      case ($urandom_range(0, 7))
         0: return 16'h4000;
         1: return 16'hC000;
         2: return 16'h7FFF;
         3: return 16'h8000;
         4: return 16'h0000;
         default: return crg_pkg::COMP_W'($urandom);
      endcase
   endfunction

   function automatic logic [crg_pkg::BASIS_W-1:0] pick_basis();
      return {pick_comp(), pick_comp(), pick_comp()};
   endfunction

   function automatic logic [crg_pkg::SIZE_W-1:0] pick_size();
      case ($urandom_range(0, 5))
         0: return crg_pkg::SIZE_W'($urandom_range(0, 3));
         1: return crg_pkg::SIZE_W'($urandom_range(8000, 8191));
         2: return crg_pkg::SIZE_W'($urandom_range(4090, 4096));
         default: return crg_pkg::SIZE_W'($urandom_range(1, 8191));
      endcase
   endfunction

   function automatic logic [crg_pkg::JIT_W-1:0] pick_jitter();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         default: return crg_pkg::JIT_W'($urandom);
      endcase
   endfunction

   function automatic logic [crg_pkg::COORD_W-1:0] pick_coord(
         logic [crg_pkg::SIZE_W-1:0] extent);
      int top;
      top = (extent == 0) ? 0 : ((extent > 4096) ? 4095 : extent - 1);
      if ($urandom_range(0, 2) == 0) return crg_pkg::COORD_W'($urandom);
      return crg_pkg::COORD_W'($urandom_range(0, top));
   endfunction

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset setup: corners, center and coordinates past the image edge.
      send_pixel(0, 0, 0, 0);
      send_pixel(639, 479, 16'hFFFF, 16'hFFFF);
      send_pixel(320, 240, 0, 0);
      send_pixel(4095, 4095, 16'hFFFF, 16'hFFFF);
      send_pixel(12'hAAA, 12'h555, 16'hAAAA, 16'h5555);
      send_pixel(12'h555, 12'hAAA, 16'h5555, 16'hAAAA);
      drain();

      // Tiny image, largest scales, extreme basis components.
      write_setup(1, 1, 16'hFFFF, 16'hFFFF, 48'h8000_7FFF_4000,
                  48'h7FFF_8000_C000, 48'h8000_8000_7FFF);
      csr_wr_en <= 1'b0;
      send_pixel(0, 0, 0, 0);
      send_pixel(4095, 4095, 16'hFFFF, 16'hFFFF);
      send_pixel(0, 4095, 16'hFFFF, 0);
      send_pixel(4095, 0, 0, 16'hFFFF);
      drain();

      // Zero sizes count as one; an all-zero basis gives a zero direction.
      // A write past the register list must change nothing.
      write_setup(0, 0, 16'h1000, 16'h1000, '0, '0, '0);
      write_reg(REG_UNUSED, '1);
      csr_wr_en <= 1'b0;
      send_pixel(0, 0, 0, 0);
      send_pixel(7, 9, 16'h8000, 16'h8000);
      drain();

      // Largest sizes with zero scales: only the back axis remains.
      write_setup(8191, 8191, 0, 0, 48'h1234_5678_9ABC, 48'hFFFF_0001_8000,
                  48'h0000_C000_0000);
      csr_wr_en <= 1'b0;
      send_pixel(0, 0, 0, 0);
      send_pixel(4095, 4095, 16'hFFFF, 16'hFFFF);
      send_pixel(2048, 100, 16'h0001, 16'hFFFE);
      drain();

      // Random setups, each followed by a stream of random pixel samples.
      for (int phase = 0; phase < 8; phase++) begin
         logic [crg_pkg::SIZE_W-1:0] w, h;
         w = pick_size();
         h = pick_size();
         write_setup(w, h, crg_pkg::SCALE_W'($urandom), crg_pkg::SCALE_W'($urandom),
                     pick_basis(), pick_basis(), pick_basis());
         csr_wr_en <= 1'b0;
         for (int n = 0; n < 235; n++)
            send_pixel(pick_coord(w), pick_coord(h), pick_jitter(), pick_jitter());
         drain();
      end

      if (ray_sb.errors == 0) begin
         $display("[camera_ray_generation] OK");
      end else begin
         $display("[camera_ray_generation] ERROR");
      end
      $finish;
   end

endmodule
